// File: rtl/stij_pkg.sv
// ----------------------------------------------------------------------------
// stij_pkg: shared types and constants for the sorted table
// Beat payloads, status and op codes, cell control structs, one-hot encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package stij_pkg;

  // table geometry
  localparam int CAPACITY    = 64;
  localparam int JUMP_STRIDE = 3;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  // fixed field widths
  localparam int DATA_W = 32;
  localparam int POS_W  = 6;
  localparam int FILL_W = 7;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_FOUND    = 2'd2,
    ST_MISSING  = 2'd3
  } status_t;

  typedef struct packed {
    op_t                      op;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    status_t           status;
    logic [POS_W-1:0]  position;
    logic [FILL_W-1:0] fill;
  } out_t;

  // per-cycle commands broadcast to every cell
  typedef struct packed {
    logic cmp_en;
    logic ins_en;
  } cell_ctl_t;

  // flags one cell reports after a compare
  typedef struct packed {
    logic bnd;   // first cell not below the key (lower bound)
    logic hl;    // lower bound holds the key
    logic hp;    // stopping probe point holds the key
  } cell_hit_t;

  // index of the set bit in a one-hot vector (zero when none set)
  function automatic logic [IDX_W-1:0] onehot_idx(input logic [CAPACITY-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (v[i]) begin
        idx = idx | IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// File: rtl/stij_cell.sv
// ----------------------------------------------------------------------------
// stij_cell: one slot of the sorted table
// Holds one entry, compares it with the key and shifts up on insert.
// ----------------------------------------------------------------------------
`default_nettype none

module stij_cell
  import stij_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  cell_ctl_t                 ctl,
  input  logic                      probe,       // slot is a jump probe point
  input  logic signed [DATA_W-1:0]  key,
  input  logic signed [DATA_W-1:0]  prev_entry,
  input  logic                      prev_valid,
  input  logic                      prev_lt,
  input  logic                      back_lt,     // lt of the previous probe point
  output logic signed [DATA_W-1:0]  entry,
  output logic                      valid,
  output logic                      lt,
  output cell_hit_t                 hit
);

  logic signed [DATA_W-1:0] entry_r, entry_nxt;
  logic                     valid_r, valid_nxt;
  logic                     lt_r, lt_nxt;
  logic                     eq_r, eq_nxt;

  // compare and insert-shift
  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    lt_nxt    = lt_r;
    eq_nxt    = eq_r;
    if (ctl.cmp_en) begin
      lt_nxt = valid_r && (entry_r < key);
      eq_nxt = valid_r && (entry_r == key);
    end
    if (ctl.ins_en && !lt_r) begin
      // lower bound takes the key, slots above take their neighbor
      entry_nxt = prev_lt ? key : prev_entry;
      valid_nxt = valid_r | prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      lt_r    <= 1'b0;
      eq_r    <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      lt_r    <= lt_nxt;
      eq_r    <= eq_nxt;
    end
  end

  // hit flags from the registered compare
  always_comb begin
    hit.bnd = !lt_r && prev_lt;
    hit.hl  = !lt_r && prev_lt && eq_r;
    hit.hp  = probe && !lt_r && back_lt && eq_r;
  end

  assign entry = entry_r;
  assign valid = valid_r;
  assign lt    = lt_r;

  // occupied slots form a run from the head
  a_valid_run: assert property (@(posedge clk) disable iff (!rst_n)
    !prev_valid |-> !valid_r)
    else $error("occupied slot above an empty one");

  // a slot below the key lies under the lower bound
  a_lt_run: assert property (@(posedge clk) disable iff (!rst_n)
    lt_r |-> prev_lt)
    else $error("below-key flags not a thermometer");

  // a probe or lower-bound hit always sits on a valid slot
  a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (hit.hp || hit.hl) |-> valid_r)
    else $error("hit on an empty slot");

endmodule

`default_nettype wire

// File: rtl/sorted_table_insert_jump_search.sv
// ----------------------------------------------------------------------------
// sorted_table_insert_jump_search: ordered table with insert and jump search
// A row of cells holds the entries in ascending order; every cell compares
// against the key in parallel and the row shifts up by one on insert.
//
//   channel | ports                   | handshake
//   --------+-------------------------+-------------------------------
//   input   | start, busy, in_data    | beat taken on start & !busy
//   result  | out_valid, out_data     | one-cycle strobe, no back-pressure
//
// Each item passes through the accept cycle, then compare (registered in
// every cell), locate (one-hot encode of the hit flags), finish (result and
// row shift). busy is high in the compare, locate and finish states.
// The result strobe comes in the cycle after finish, when busy is already low.
// Reset clears the occupancy bits and the count; no memory clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_insert_jump_search
  import stij_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_LOC  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [DATA_W-1:0] key_r;
  op_t                      op_r;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [IDX_W-1:0]         l_pos_r, p_pos_r;
  logic                     hl_any_r, hp_any_r;
  logic                     out_valid_r, out_valid_nxt;
  out_t                     out_r, out_nxt;

  cell_ctl_t                ctl;
  logic signed [DATA_W-1:0] entry_w [CAPACITY];
  logic [CAPACITY-1:0]      valid_v, lt_v, bnd_v, hl_v, hp_v;
  logic                     full;
  logic                     accept;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);
  assign full   = (count_r == CNT_W'(CAPACITY));

  // the row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic IS_PROBE = ((i % JUMP_STRIDE) == 0) && (i >= JUMP_STRIDE);
    logic signed [DATA_W-1:0] prev_entry;
    logic                     prev_valid, prev_lt, back_lt;
    cell_hit_t                hit;

    if (i == 0) begin : g_head
      assign prev_entry = '0;
      assign prev_valid = 1'b1;
      assign prev_lt    = 1'b1;
    end else begin : g_link
      assign prev_entry = entry_w[i-1];
      assign prev_valid = valid_v[i-1];
      assign prev_lt    = lt_v[i-1];
    end

    // first probe has only the start point behind it
    if (IS_PROBE && (i > JUMP_STRIDE)) begin : g_back
      assign back_lt = lt_v[i-JUMP_STRIDE];
    end else begin : g_back_tie
      assign back_lt = IS_PROBE;
    end

    stij_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .probe      (IS_PROBE),
      .key        (key_r),
      .prev_entry (prev_entry),
      .prev_valid (prev_valid),
      .prev_lt    (prev_lt),
      .back_lt    (back_lt),
      .entry      (entry_w[i]),
      .valid      (valid_v[i]),
      .lt         (lt_v[i]),
      .hit        (hit)
    );

    assign bnd_v[i] = hit.bnd;
    assign hl_v[i]  = hit.hl;
    assign hp_v[i]  = hit.hp;
  end

  // cell commands
  always_comb begin
    ctl.cmp_en = (state_r == S_CMP);
    ctl.ins_en = (state_r == S_FIN) && (op_r == OP_INSERT) && !full;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) begin
                 state_nxt = S_CMP;
               end
      S_CMP:   state_nxt = S_LOC;
      S_LOC:   state_nxt = S_FIN;
      S_FIN:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // finish: result beat and count update
  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    if (state_r == S_FIN) begin
      out_valid_nxt = 1'b1;
      if (op_r == OP_INSERT) begin
        if (full) begin
          out_nxt.status   = ST_FULL;
          out_nxt.position = '0;
        end else begin
          count_nxt        = count_r + CNT_W'(1);
          out_nxt.status   = ST_INSERTED;
          out_nxt.position = POS_W'(l_pos_r);
        end
      end else begin
        priority if (hp_any_r) begin
          out_nxt.status   = ST_FOUND;
          out_nxt.position = POS_W'(p_pos_r);
        end else if (hl_any_r) begin
          out_nxt.status   = ST_FOUND;
          out_nxt.position = POS_W'(l_pos_r);
        end else begin
          out_nxt.status   = ST_MISSING;
          out_nxt.position = '0;
        end
      end
      out_nxt.fill = FILL_W'(count_nxt);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= in_data.value;
      op_r  <= in_data.op;
    end
    if (state_r == S_LOC) begin
      l_pos_r  <= onehot_idx(bnd_v);
      p_pos_r  <= onehot_idx(hp_v);
      hl_any_r <= |hl_v;
      hp_any_r <= |hp_v;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // every accepted beat yields its result strobe after finish
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("result strobe missing after accept");

  // count never passes the capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  // count tracks the occupied slots
  a_count_valid: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'($countones(valid_v)) == count_r)
    else $error("count out of step with occupied slots");

  // at most one lower bound and one probe stop
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOC) |-> ($onehot0(bnd_v) && $onehot0(hp_v)))
    else $error("multiple hit flags in the row");

endmodule

`default_nettype wire

// File: tb/tb_sorted_table_insert_jump_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_table_insert_jump_search: self-checking bench for the sorted table
// Drives insert and search commands through the start/busy port and keeps a
// software copy of the ordered table. Every accepted command is predicted
// there, and each result strobe is checked field by field against the oldest
// prediction. Directed cases come first. The random part then fills the
// table with a mix of duplicate-heavy and wide values, and hammers searches
// on the full table.
// ----------------------------------------------------------------------------

module tb_sorted_table_insert_jump_search;
  import stij_pkg::*;

  localparam int TOTAL_ITEMS    = 1850;
  localparam int QUIET_TAIL     = 300;
  localparam int WATCHDOG_LIMIT = 500;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  // one queued command beat plus its pacing
  typedef struct {
    in_t         beat;
    int unsigned idle;
    bit          drain;
  } cmd_t;

  logic clk     = 1'b0;
  logic rst_n   = 1'b0;
  logic start   = 1'b0;
  in_t  in_data = '0;
  logic busy;
  logic out_valid;
  out_t out_data;

  sorted_table_insert_jump_search dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // stimulus side
  cmd_t                      cmd_queue[$];
  logic signed [DATA_W-1:0]  inserted_vals[$];
  int unsigned               items_queued = 0;
  bit                        idling_on    = 1'b0;

  // shadow table and expected results
  logic signed [DATA_W-1:0]  tbl[CAPACITY];
  int                        tbl_fill = 0;
  out_t                      replies_due[$];

  // bookkeeping
  logic        beat_taken = 1'b0;
  int unsigned idle_wait  = 0;
  int unsigned n_accepted = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_inserted = 0, n_refused = 0, n_found = 0, n_missing = 0;

  // Apply one command to the shadow table and return the result it should give
  function automatic out_t table_apply(in_t beat);
    out_t                     r;
    logic signed [DATA_W-1:0] key;
    int                       pos;
    int                       probe;
    int                       blk;
    key        = beat.value;
    r.status   = ST_MISSING;
    r.position = '0;
    if (beat.op == OP_INSERT) begin
      if (tbl_fill >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        // new value lands ahead of any equal entries
        pos = 0;
        while (pos < tbl_fill && tbl[pos] < key) pos++;
        for (int i = tbl_fill; i > pos; i--) tbl[i] = tbl[i-1];
        tbl[pos]   = key;
        tbl_fill++;
        r.status   = ST_INSERTED;
        r.position = POS_W'(pos);
      end
    end else if (tbl_fill != 0) begin
      // jump phase: probe saturates at the fill level
      probe = 0;
      do begin
        blk   = probe;
        probe = probe + JUMP_STRIDE;
        if (probe > tbl_fill) probe = tbl_fill;
      end while (probe < tbl_fill && key > tbl[probe]);
      if (probe < tbl_fill && key == tbl[probe]) begin
        r.status   = ST_FOUND;
        r.position = POS_W'(probe);
      end else begin
        // linear scan of the block behind the stop point, first hit wins
        for (int i = blk; i < probe; i++) begin
          if (r.status != ST_FOUND && tbl[i] == key) begin
            r.status   = ST_FOUND;
            r.position = POS_W'(i);
          end
        end
      end
    end
    r.fill = FILL_W'(tbl_fill);
    return r;
  endfunction

  // Queue one command; idle bursts are drawn on or off anew every 40 beats
  task automatic add_item(op_t op, logic signed [DATA_W-1:0] v, bit drain);
    cmd_t c;
    if (items_queued % 40 == 0) idling_on = $urandom_range(1);
    c.beat.op    = op;
    c.beat.value = v;
    c.drain      = drain;
    c.idle       = 0;
    if (idling_on && items_queued < TOTAL_ITEMS - QUIET_TAIL && $urandom_range(99) < 35)
      c.idle = $urandom_range(10, 1);
    cmd_queue.push_back(c);
    if (op == OP_INSERT) inserted_vals.push_back(v);
    items_queued++;
  endtask

  // Insert values: many small ones so duplicates pile up, some extremes
  function automatic logic signed [DATA_W-1:0] pick_insert_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return $signed(DATA_W'($urandom_range(8))) - 4;
    if (r < 45) return ($urandom_range(1) != 0) ? VAL_MAX : VAL_MIN;
    return $signed($urandom);
  endfunction

  // Search keys: mostly held values, neighbors of held values, extremes, noise
  function automatic logic signed [DATA_W-1:0] pick_search_key();
    int unsigned              r;
    logic signed [DATA_W-1:0] v;
    r = $urandom_range(99);
    if (inserted_vals.size() != 0 && r < 70) begin
      v = inserted_vals[$urandom_range(inserted_vals.size() - 1)];
      if (r < 55) return v;
      return ($urandom_range(1) != 0) ? v + 1 : v - 1;
    end
    case ($urandom_range(5))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return -1;
      default: return $signed($urandom);
    endcase
  endfunction

  // Driver: change inputs on the falling edge, one beat at a time
  always @(negedge clk) begin
    if (!rst_n) begin
      start     <= 1'b0;
      idle_wait <= 0;
    end else if (!start || beat_taken) begin
      if (cmd_queue.size() == 0) begin
        start <= 1'b0;
      end else if (idle_wait < cmd_queue[0].idle) begin
        idle_wait <= idle_wait + 1;
        start     <= 1'b0;
      end else if (cmd_queue[0].drain && replies_due.size() != 0) begin
        start <= 1'b0;
      end else begin
        in_data   <= cmd_queue[0].beat;
        idle_wait <= 0;
        start     <= 1'b1;
        cmd_queue.pop_front();
      end
    end
  end

  // Monitor: check result strobes, predict accepted beats
  always @(posedge clk) begin : monitor
    out_t want;
    out_t got;
    beat_taken <= rst_n && start && !busy;
    if (rst_n) begin
      if (out_valid) begin
        if (replies_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] unexpected result: status=%0d position=%0d fill=%0d",
                     $realtime, out_data.status, out_data.position, out_data.fill);
        end else begin
          want = replies_due.pop_front();
          if (out_data.status !== want.status || out_data.position !== want.position ||
              out_data.fill !== want.fill) begin
            fail_count++;
            if (fail_count <= 10)
              $display("[%0t] mismatch: exp status=%0d pos=%0d fill=%0d, got %0d/%0d/%0d",
                       $realtime, want.status, want.position, want.fill,
                       out_data.status, out_data.position, out_data.fill);
          end
        end
      end
      if (start && !busy) begin
        got = table_apply(in_data);
        replies_due.push_back(got);
        n_accepted++;
        case (got.status)
          ST_INSERTED: n_inserted++;
          ST_FULL:     n_refused++;
          ST_FOUND:    n_found++;
          default:     n_missing++;
        endcase
      end
    end
  end

  // Watchdog: too long with neither a beat taken nor a result seen
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no progress for %0d cycles", $realtime, quiet_cycles);
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    bit drain_next;
    // empty-table search, then extremes and equal values on insert
    add_item(OP_SEARCH, 0, 1'b0);
    add_item(OP_INSERT, 0, 1'b0);
    add_item(OP_INSERT, VAL_MIN, 1'b0);
    add_item(OP_INSERT, VAL_MAX, 1'b0);
    add_item(OP_INSERT, 0, 1'b0);
    add_item(OP_INSERT, -1, 1'b0);
    add_item(OP_INSERT, 1, 1'b0);
    add_item(OP_INSERT, VAL_MIN, 1'b0);
    // probe hit on a duplicate, scan hits, misses
    add_item(OP_SEARCH, 0, 1'b0);
    add_item(OP_SEARCH, VAL_MIN, 1'b0);
    add_item(OP_SEARCH, VAL_MAX, 1'b0);
    add_item(OP_SEARCH, 1, 1'b0);
    add_item(OP_SEARCH, 2, 1'b0);
    add_item(OP_SEARCH, -2, 1'b0);
    add_item(OP_SEARCH, VAL_MAX - 1, 1'b0);
    // fill of eight: last probe saturates at the end of the table
    add_item(OP_INSERT, 5, 1'b0);
    add_item(OP_SEARCH, VAL_MAX, 1'b0);
    add_item(OP_SEARCH, 6, 1'b0);

    // fill phase: inserts mixed with searches at every fill level
    while (inserted_vals.size() < 72) begin
      if ($urandom_range(99) < 60) add_item(OP_INSERT, pick_insert_value(), 1'b0);
      else add_item(OP_SEARCH, pick_search_key(), 1'b0);
    end

    // full table: mostly searches, some refused inserts
    drain_next = 1'b1;
    while (items_queued < TOTAL_ITEMS) begin
      if (items_queued == TOTAL_ITEMS / 2) drain_next = 1'b1;
      if ($urandom_range(99) < 15) add_item(OP_INSERT, pick_insert_value(), drain_next);
      else add_item(OP_SEARCH, pick_search_key(), drain_next);
      drain_next = 1'b0;
    end

    // reset held from time zero, released on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (n_accepted != items_queued) @(negedge clk);
    while (replies_due.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);

    $display("Ran %0d beats: %0d inserts, %0d refused on full table, %0d found, %0d missing",
             n_accepted, n_inserted, n_refused, n_found, n_missing);
    $display("Final fill %0d of %0d, %0d failures", tbl_fill, CAPACITY, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
